@@ design/cqr_pkg.sv @@
// ----------------------------------------------------------------------------
// cqr_pkg
// Shared types and codes for the circular queue with reverse: command and
// status codes, beat payloads and the stage record passed to the output side.
// ----------------------------------------------------------------------------
`default_nettype none

package cqr_pkg;

   localparam int CMD_W       = 2;
   localparam int STATUS_W    = 2;
   localparam int VALUE_W     = 32;
   localparam int INDEX_W     = 10;
   localparam int COUNT_OUT_W = 11;
   localparam int EXT_W       = 64;

   typedef logic [CMD_W-1:0]    cmd_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam cmd_type CMD_PUSH    = 2'd0;
   localparam cmd_type CMD_POP     = 2'd1;
   localparam cmd_type CMD_GET     = 2'd2;
   localparam cmd_type CMD_REVERSE = 2'd3;

   localparam status_type STATUS_OK    = 2'd0;
   localparam status_type STATUS_EMPTY = 2'd1;
   localparam status_type STATUS_RANGE = 2'd2;
   localparam status_type STATUS_FULL  = 2'd3;

   typedef struct packed {
      cmd_type                    cmd;
      logic signed [VALUE_W-1:0]  push_value;
      logic [INDEX_W-1:0]         read_index;
   } req_payload_type;

   typedef struct packed {
      status_type                 status;
      logic signed [VALUE_W-1:0]  read_value;
      logic [COUNT_OUT_W-1:0]     item_count;
   } rsp_payload_type;

   // What the output side needs to know about a command once it has left
   // the pointer logic.
   typedef struct packed {
      status_type             status;
      logic                   is_get;
      logic [COUNT_OUT_W-1:0] item_count;
   } stage_info_type;

endpackage

`default_nettype wire

@@ design/cqr_ifs.sv @@
// ----------------------------------------------------------------------------
// cqr_ifs
// Valid/ready channel interfaces for the command beats and the result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface cqr_req_if import cqr_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface cqr_rsp_if import cqr_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ design/cqr_mem.sv @@
// ----------------------------------------------------------------------------
// cqr_mem
// Single-port synchronous storage for the queue elements, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module cqr_mem import cqr_pkg::*; #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ design/cqr_ctrl.sv @@
// ----------------------------------------------------------------------------
// cqr_ctrl
// Head pointer, element count and direction flag. Maps each command to one
// physical slot and issues the single storage access it needs.
// ----------------------------------------------------------------------------
`default_nettype none

module cqr_ctrl import cqr_pkg::*; #(
   parameter int CAPACITY = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  cmd_type                     cmd,
   input  logic [INDEX_W-1:0]          read_index,
   output logic                        mem_wr_en,
   output logic                        mem_rd_en,
   output logic [$clog2(CAPACITY)-1:0] mem_addr,
   output stage_info_type              info
);

   localparam int AW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;
   localparam logic [AW:0]   CAP_A = (AW + 1)'(CAPACITY);
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

   logic [AW-1:0] head_ff,  head_in;
   logic [CW-1:0] count_ff, count_in;
   logic          rev_ff,   rev_in;

   logic [AW-1:0] offset;
   logic [AW:0]   fwd_sum;
   logic [AW:0]   rev_sum;
   logic [AW-1:0] slot;
   status_type    status;
   logic          full;
   logic          empty;
   logic          in_range;

   assign full     = (count_ff == CAP_C);
   assign empty    = (count_ff == '0);
   assign in_range = (CMPW'(read_index) < CMPW'(count_ff));

   // Logical offset from the front for each command. Only offsets below the
   // capacity are ever used, so the modulo reduces to one compare-subtract.
   always_comb begin
      case (cmd)
         CMD_PUSH: offset = AW'(count_ff);
         CMD_POP:  offset = AW'(1);
         CMD_GET:  offset = AW'(read_index);
         default:  offset = AW'(count_ff - CW'(1));
      endcase
   end

   assign fwd_sum = {1'b0, head_ff} + {1'b0, offset};
   assign rev_sum = {1'b0, head_ff} + CAP_A - {1'b0, offset};

   always_comb begin
      if (rev_ff) begin
         slot = (rev_sum >= CAP_A) ? AW'(rev_sum - CAP_A) : AW'(rev_sum);
      end else begin
         slot = (fwd_sum >= CAP_A) ? AW'(fwd_sum - CAP_A) : AW'(fwd_sum);
      end
   end

   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      rev_in    = rev_ff;
      status    = STATUS_OK;
      mem_wr_en = 1'b0;
      mem_rd_en = 1'b0;
      case (cmd)
         CMD_PUSH: begin
            if (full) begin
               status = STATUS_FULL;
            end else begin
               mem_wr_en = accept;
               count_in  = count_ff + CW'(1);
            end
         end
         CMD_POP: begin
            if (empty) begin
               status = STATUS_EMPTY;
            end else begin
               head_in  = slot;
               count_in = count_ff - CW'(1);
            end
         end
         CMD_GET: begin
            if (!in_range) begin
               status = STATUS_RANGE;
            end else begin
               mem_rd_en = accept;
            end
         end
         default: begin
            // The old logical back becomes the front; data stays in place.
            if (!empty) begin
               head_in = slot;
            end
            rev_in = !rev_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         rev_ff   <= 1'b0;
      end else if (accept) begin
         head_ff  <= head_in;
         count_ff <= count_in;
         rev_ff   <= rev_in;
      end
   end

   assign mem_addr        = slot;
   assign info.status     = status;
   assign info.is_get     = (cmd == CMD_GET);
   assign info.item_count = COUNT_OUT_W'(count_in);

endmodule

`default_nettype wire

@@ design/cqr_out.sv @@
// ----------------------------------------------------------------------------
// cqr_out
// Result side: a stage that waits for the storage read data, then an output
// register that holds the result beat while the receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module cqr_out import cqr_pkg::*; #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  stage_info_type        info,
   input  logic [DATA_WIDTH-1:0] rdata,
   output logic                  in_ready,
   cqr_rsp_if.source             rsp
);

   logic            s1_valid_ff, s1_valid_in;
   stage_info_type  s1_info_ff;
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_ff, out_in;
   logic            out_load;
   logic [EXT_W-1:0] rdata_ext;

   // The stored word is sign-extended from its own width; the low bits of
   // that form the reported value.
   assign rdata_ext = EXT_W'(signed'(rdata));

   assign out_load = s1_valid_ff && (!out_valid_ff || rsp.ready);
   assign in_ready = !s1_valid_ff || out_load;

   always_comb begin
      out_in.status     = s1_info_ff.status;
      out_in.item_count = s1_info_ff.item_count;
      if (!s1_info_ff.is_get) begin
         out_in.read_value = '0;
      end else if (s1_info_ff.status == STATUS_RANGE) begin
         out_in.read_value = '1;
      end else begin
         out_in.read_value = rdata_ext[VALUE_W-1:0];
      end
   end

   assign s1_valid_in  = accept || (s1_valid_ff && !out_load);
   assign out_valid_in = out_load || (out_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_info_ff <= info;
      end
      if (out_load) begin
         out_ff <= out_in;
      end
   end

   assign rsp.valid   = out_valid_ff;
   assign rsp.payload = out_ff;

endmodule

`default_nettype wire

@@ design/circular_queue_with_reverse_core.sv @@
// ----------------------------------------------------------------------------
// circular_queue_with_reverse_core
// Ring-buffer queue of signed words with push, pop, indexed get and reverse.
// ----------------------------------------------------------------------------
// Commands arrive as beats on req_ch (valid/ready); every command gives one
// result beat on rsp_ch carrying a status, the value read by a get and the
// element count after the command.
// A command needs at most one storage access, so one beat is accepted per
// cycle unless the output side stalls. The accepting edge registers the
// storage read and stage record; the output register takes them once free.
// Reverse only toggles a direction flag and moves the head pointer; push and
// pop then act on the other physical end, and get indexes downwards.
// Each access is issued at its own accepting edge and the storage has a
// single port, so a get straight after a push already sees the new word.
// Reset clears the head, count and direction flag and holds req_ch.ready low;
// storage is not cleared, as no get can reach a slot that was never pushed.
// When the receiver stalls, the output register holds its beat and one more
// command may be taken into the read stage; after that req_ch.ready falls
// until the receiver takes a beat.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_queue_with_reverse_core import cqr_pkg::*; #(
   parameter int CAPACITY   = 1024,
   parameter int DATA_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   cqr_req_if.sink     req_ch,
   cqr_rsp_if.source   rsp_ch
);

   localparam int AW = $clog2(CAPACITY);

   logic                  accept;
   logic                  in_ready;
   logic                  mem_wr_en;
   logic                  mem_rd_en;
   logic [AW-1:0]         mem_addr;
   logic [DATA_WIDTH-1:0] mem_wdata;
   logic [DATA_WIDTH-1:0] mem_rdata;
   stage_info_type        info;

   assign req_ch.ready = in_ready && !reset;
   assign accept       = req_ch.valid && in_ready && !reset;
   assign mem_wdata    = DATA_WIDTH'($unsigned(req_ch.payload.push_value));

   cqr_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .cmd        (req_ch.payload.cmd),
      .read_index (req_ch.payload.read_index),
      .mem_wr_en  (mem_wr_en),
      .mem_rd_en  (mem_rd_en),
      .mem_addr   (mem_addr),
      .info       (info)
   );

   cqr_mem #(
      .DEPTH (CAPACITY),
      .WIDTH (DATA_WIDTH)
   ) u_mem (
      .clock (clock),
      .wr_en (mem_wr_en),
      .rd_en (mem_rd_en),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   cqr_out #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_out (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .info     (info),
      .rdata    (mem_rdata),
      .in_ready (in_ready),
      .rsp      (rsp_ch)
   );

endmodule

`default_nettype wire

@@ test/circular_queue_with_reverse_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_queue_with_reverse_core_tb
// Self-checking bench for the circular queue with reverse. A mirror of the
// ring buffer (head, count, direction flag and storage) predicts one result
// per accepted command. Each result beat is then compared field by field
// with the oldest prediction. A short directed sequence comes first. Random
// traffic follows: mixed commands, a fill to capacity with probes at the
// full queue, and a pop-heavy drain. Sender and receiver idle at changing
// rates.
// ----------------------------------------------------------------------------

module circular_queue_with_reverse_core_tb import cqr_pkg::*;;

   localparam int DEPTH = 1024;

   class ring_queue_mirror;
      logic [VALUE_W-1:0]     storage [DEPTH];
      logic [INDEX_W-1:0]     head;
      logic [COUNT_OUT_W-1:0] fill;
      logic                   reversed;
      rsp_payload_type        pending_results [$];
      int                     failures;

      function new();
         head     = '0;
         fill     = '0;
         reversed = 1'b0;
         failures = 0;
      endfunction

      // Physical slot of a logical position; 10-bit arithmetic wraps the ring.
      function logic [INDEX_W-1:0] slot_for(input int unsigned logical);
         logic [INDEX_W-1:0] offset;
         offset = logical[INDEX_W-1:0];
         return reversed ? head - offset : head + offset;
      endfunction

      function void note_command(input req_payload_type p);
         rsp_payload_type e;
         e.status     = STATUS_OK;
         e.read_value = '0;
         case (p.cmd)
            CMD_PUSH: begin
               if (fill >= DEPTH) begin
                  e.status = STATUS_FULL;
               end else begin
                  storage[slot_for(fill)] = p.push_value;
                  fill = fill + 1'b1;
               end
            end
            CMD_POP: begin
               if (fill == 0) begin
                  e.status = STATUS_EMPTY;
               end else begin
                  head = slot_for(1);
                  fill = fill - 1'b1;
               end
            end
            CMD_GET: begin
               if (p.read_index >= fill) begin
                  e.status     = STATUS_RANGE;
                  e.read_value = -1;
               end else begin
                  e.read_value = storage[slot_for(p.read_index)];
               end
            end
            default: begin
               if (fill != 0) head = slot_for(fill - 1);
               reversed = !reversed;
            end
         endcase
         e.item_count = fill;
         pending_results.push_back(e);
      endfunction

      function void check_result(input rsp_payload_type r);
         rsp_payload_type e;
         if (pending_results.size() == 0) begin
            $error("result beat with no command outstanding: status %0d value %0d count %0d",
                   r.status, r.read_value, r.item_count);
            failures++;
            return;
         end
         e = pending_results.pop_front();
         if (r.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, r.status);
            failures++;
         end
         if (r.read_value !== e.read_value) begin
            $error("read_value: expected %0d, got %0d", e.read_value, r.read_value);
            failures++;
         end
         if (r.item_count !== e.item_count) begin
            $error("item_count: expected %0d, got %0d", e.item_count, r.item_count);
            failures++;
         end
      endfunction

      function int outstanding();
         return pending_results.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   int   idle_pct;
   int   stall_pct;

   ring_queue_mirror mirror;

   cqr_req_if req_ch ();
   cqr_rsp_if rsp_ch ();

   circular_queue_with_reverse_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #6 clock = ~clock;

   // Receiver: checks every accepted result beat and stalls at random.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) mirror.check_result(rsp_ch.payload);
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // The command is noted by the driver itself, so the mirror's count is
   // current when the next command is chosen.
   task automatic send_command(input cmd_type c, input logic [VALUE_W-1:0] v,
                               input logic [INDEX_W-1:0] idx);
      req_payload_type p;
      int              gap;
      p.cmd        = c;
      p.push_value = v;
      p.read_index = idx;
      gap = 0;
      while ($urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= p;
      do @(posedge clock); while (!req_ch.ready);
      mirror.note_command(p);
   endtask

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(7))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'hffff_ffff;
         3:       return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   // Mostly indexes that hit a held element; the rest span the whole field.
   function automatic logic [INDEX_W-1:0] pick_index();
      if (mirror.fill != 0 && $urandom_range(9) < 8)
         return INDEX_W'($urandom_range(mirror.fill - 1, 0));
      return INDEX_W'($urandom_range(DEPTH - 1, 0));
   endfunction

   task automatic run_mix(input int beats, input int push_w, input int pop_w,
                          input int get_w);
      int r;
      repeat (beats) begin
         r = $urandom_range(99);
         if (r < push_w)
            send_command(CMD_PUSH, pick_value(), INDEX_W'($urandom));
         else if (r < push_w + pop_w)
            send_command(CMD_POP, $urandom, INDEX_W'($urandom));
         else if (r < push_w + pop_w + get_w)
            send_command(CMD_GET, $urandom, pick_index());
         else
            send_command(CMD_REVERSE, $urandom, INDEX_W'($urandom));
      end
   endtask

   initial begin
      mirror = new();
      idle_pct  = 30;
      stall_pct = 84;
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.payload <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty-queue corner cases, value extremes, reverse with data.
      send_command(CMD_GET, '0, 10'd0);
      send_command(CMD_GET, '0, 10'd1023);
      send_command(CMD_POP, '0, '0);
      send_command(CMD_REVERSE, '0, '0);
      send_command(CMD_REVERSE, '0, '0);
      send_command(CMD_PUSH, 32'h8000_0000, '0);
      send_command(CMD_PUSH, 32'h7fff_ffff, '0);
      send_command(CMD_PUSH, 32'hffff_ffff, '0);
      send_command(CMD_PUSH, 32'h0000_0000, '0);
      send_command(CMD_GET, '0, 10'd0);
      send_command(CMD_GET, '0, 10'd1);
      send_command(CMD_GET, '0, 10'd2);
      send_command(CMD_GET, '0, 10'd3);
      send_command(CMD_GET, '0, 10'd4);
      send_command(CMD_REVERSE, '0, '0);
      send_command(CMD_GET, '0, 10'd0);
      send_command(CMD_GET, '0, 10'd3);
      send_command(CMD_PUSH, 32'h1234_5678, '0);
      send_command(CMD_GET, '0, 10'd4);
      send_command(CMD_POP, '0, '0);
      send_command(CMD_GET, '0, 10'd0);
      send_command(CMD_REVERSE, '0, '0);
      send_command(CMD_POP, '0, '0);
      send_command(CMD_GET, '0, 10'd0);

      run_mix(250, 35, 25, 30);

      // Fill to capacity, with the occasional get or reverse on the way.
      idle_pct  = 84;
      stall_pct = 30;
      while (mirror.fill < DEPTH) begin
         if ($urandom_range(99) < 92)
            send_command(CMD_PUSH, pick_value(), INDEX_W'($urandom));
         else if ($urandom_range(1) == 0)
            send_command(CMD_GET, $urandom, pick_index());
         else
            send_command(CMD_REVERSE, $urandom, INDEX_W'($urandom));
      end

      // Probes at the full queue, then a pop-heavy drain.
      idle_pct  = 0;
      stall_pct = 0;
      repeat (4) send_command(CMD_PUSH, pick_value(), INDEX_W'($urandom));
      send_command(CMD_GET, '0, 10'd1023);
      send_command(CMD_GET, '0, 10'd0);
      send_command(CMD_REVERSE, '0, '0);
      send_command(CMD_GET, '0, 10'd1023);
      send_command(CMD_GET, '0, 10'd0);
      send_command(CMD_POP, '0, '0);
      send_command(CMD_PUSH, pick_value(), '0);
      send_command(CMD_PUSH, pick_value(), '0);
      repeat (10) send_command(CMD_GET, '0, pick_index());
      run_mix(350, 15, 45, 30);

      req_ch.valid <= 1'b0;
      while (mirror.outstanding() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mirror.failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

@@ files.f @@
design/cqr_pkg.sv
design/cqr_ifs.sv
design/cqr_mem.sv
design/cqr_ctrl.sv
design/cqr_out.sv
design/circular_queue_with_reverse_core.sv
test/circular_queue_with_reverse_core_tb.sv
